FILE: rtl/core/egas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egas_pkg: shared types and constants of the epsilon-greedy arm selector
// item structs, opcodes, register indexes, arithmetic widths, token type
// ----------------------------------------------------------------------------
package egas_pkg;

	localparam int ARMS_DEF   = 16;
	localparam int CNT_W      = 16;
	localparam int EST_W      = 24;
	localparam int DIVD_W     = 25;
	localparam int DIVS_W     = CNT_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 18;

	localparam logic [CNT_W-1:0]        CNT_MAX = '1;
	localparam logic signed [EST_W-1:0] EST_MAX = {1'b0, {(EST_W-1){1'b1}}};
	localparam logic signed [EST_W-1:0] EST_MIN = {1'b1, {(EST_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_SELECT  = 2'd0,
		OP_UPDATE  = 2'd1,
		OP_RESTART = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EPSILON     = 2'd0,
		REG_INIT_VALUE  = 2'd1,
		REG_ARMS_IN_USE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [15:0]        random_draw;
		logic [3:0]         random_arm;
		logic [3:0]         arm;
		logic signed [15:0] reward;
	} in_item_t;

	typedef struct packed {
		logic [3:0] chosen_arm;
		logic       explored;
	} out_item_t;

	// best-so-far record handed from cell to cell during a scan
	typedef struct packed {
		logic                    valid;
		logic                    empty;
		logic signed [EST_W-1:0] value;
	} token_t;

	// load command for one cell (restart or reward write)
	typedef struct packed {
		logic                    load;
		logic [CNT_W-1:0]        count;
		logic signed [EST_W-1:0] est;
	} cell_ctl_t;

endpackage

FILE: rtl/core/egas_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egas_div: unsigned restoring divider
// one quotient bit per cycle, done pulses after the last bit
// ----------------------------------------------------------------------------
module egas_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [egas_pkg::DIVD_W-1:0] dividend,
	input  logic [egas_pkg::DIVS_W-1:0] divisor,
	output logic                        done,
	output logic [egas_pkg::DIVD_W-1:0] quotient
);
	import egas_pkg::*;

	localparam int STEP_W = $clog2(DIVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] dvs_q;
	logic [DIVS_W:0]   rem_sh;
	logic              fits;

	// partial remainder stays below the divisor, so it fits the divisor width
	assign rem_sh = {rem_q, quo_q[DIVD_W-1]};
	assign fits   = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == STEP_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DIVS_W'(rem_sh - {1'b0, dvs_q}) : rem_sh[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/core/egas_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// egas_cell: one arm of the selector chain
// holds the arm's count and estimate, compares against the passing token
// ----------------------------------------------------------------------------
module egas_cell #(
	parameter int  ARMS     = egas_pkg::ARMS_DEF,
	parameter int  CELL_IDX = 0,
	localparam int IDX_W    = $clog2(ARMS),
	localparam int N_W      = $clog2(ARMS + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [N_W-1:0]                     arm_limit,
	input  egas_pkg::cell_ctl_t                ctl,
	input  egas_pkg::token_t                   tok_in,
	input  logic [IDX_W-1:0]                   tok_idx_in,
	output egas_pkg::token_t                   tok_out,
	output logic [IDX_W-1:0]                   tok_idx_out,
	output logic [egas_pkg::CNT_W-1:0]         count,
	output logic signed [egas_pkg::EST_W-1:0]  est
);
	import egas_pkg::*;

	logic [CNT_W-1:0]        count_q;
	logic signed [EST_W-1:0] est_q;
	token_t                  tok_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    active;
	logic                    take;

	assign active = 32'(arm_limit) > CELL_IDX;
	// strict compare keeps the lower index on ties
	assign take   = active && (tok_in.empty || ($signed(est_q) > $signed(tok_in.value)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			est_q   <= '0;
			tok_q   <= '0;
		end else begin
			if (ctl.load) begin
				count_q <= ctl.count;
				est_q   <= ctl.est;
			end
			tok_q.valid <= tok_in.valid;
			tok_q.empty <= take ? 1'b0 : tok_in.empty;
			tok_q.value <= take ? est_q : tok_in.value;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= take ? IDX_W'(CELL_IDX) : tok_idx_in;
	end

	assign tok_out     = tok_q;
	assign tok_idx_out = idx_q;
	assign count       = count_q;
	assign est         = est_q;

endmodule

FILE: rtl/core/epsilon_greedy_arm_selector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epsilon_greedy_arm_selector: epsilon-greedy bandit agent
// per-arm pull counts and Q16.8 running means kept in a chain of arm cells
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid / in_stall / in_data) takes one item per transfer:
//   select, reward update, restart or no-op. only select yields a result,
//   sent on the out channel (out_valid / out_stall / out_data).
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   epsilon, init_value and arms_in_use; cfg_ready is always high; writes
//   are to be made while the block is idle, which the block does not enforce.
// timing
//   one item at a time; in_stall is high while an item is in progress.
//   exploring select: goes from idle straight to the emit state.
//   greedy select: token walks the ARMS cells in the scan state, then emit.
//   update: fetch, prep, divide (25 quotient bits, then done), write;
//   in_stall stays high throughout; the divider yields one quotient bit per cycle.
//   restart: loads every cell in the transfer cycle, next item right after.
// reset and stall
//   reset clears all counts and estimates and loads the default registers.
//   a finished result waits in a holding state while the output register is
//   full and out_stall is high; new items are taken once it has moved on.
// ----------------------------------------------------------------------------
module epsilon_greedy_arm_selector #(
	parameter int ARMS = egas_pkg::ARMS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  egas_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output egas_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [egas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [egas_pkg::CFG_DATA_W-1:0] cfg_data
);
	import egas_pkg::*;

	localparam int IDX_W = $clog2(ARMS);
	localparam int N_W   = $clog2(ARMS + 1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SCAN  = 7'b0000010,
		S_EMIT  = 7'b0000100,
		S_FETCH = 7'b0001000,
		S_PREP  = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_WRITE = 7'b1000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [17:0]        epsilon_q;
	logic signed [15:0] init_value_q;
	logic [4:0]         arms_in_use_q;

	// result holding and output registers
	out_item_t res_q;
	out_item_t out_q;
	logic      out_valid_q;

	// update datapath registers
	logic [IDX_W-1:0]        upd_arm_q;
	logic signed [15:0]      reward_q;
	logic [CNT_W-1:0]        new_cnt_q;
	logic signed [EST_W-1:0] est_old_q;
	logic signed [DIVD_W-1:0] diff_q;

	// chain wiring
	token_t                  tok [ARMS+1];
	logic [IDX_W-1:0]        tok_idx [ARMS+1];
	cell_ctl_t               ctl [ARMS];
	logic [CNT_W-1:0]        cnt_arr [ARMS];
	logic signed [EST_W-1:0] est_arr [ARMS];

	logic             in_xfer;
	logic             out_free;
	logic [N_W-1:0]   arm_limit;
	logic             explore;
	logic [3:0]       rand_pick;
	logic             restart_now;
	logic             write_now;
	logic             arm_ok;

	logic [CNT_W-1:0]        fetch_cnt;
	logic signed [EST_W-1:0] fetch_est;
	logic [CNT_W-1:0]        fetch_cnt_inc;
	logic signed [DIVD_W-1:0] fetch_diff;
	logic [DIVD_W-1:0]       diff_mag;

	logic                    div_done;
	logic [DIVD_W-1:0]       div_quo;
	logic signed [DIVD_W:0]  step_signed;
	logic signed [DIVD_W:0]  est_sum;
	logic signed [EST_W-1:0] est_new;

	assign in_xfer   = in_valid && !in_stall;
	assign in_stall  = state_q != S_IDLE;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	// effective arm count: zero acts as one, large values clip to ARMS
	always_comb begin
		logic [31:0] aiu;
		aiu = 32'(arms_in_use_q);
		if (aiu == 32'd0) begin
			arm_limit = N_W'(1);
		end else if (aiu > 32'(ARMS)) begin
			arm_limit = N_W'(ARMS);
		end else begin
			arm_limit = N_W'(aiu);
		end
	end

	// explore decision and clamped random arm
	always_comb begin
		logic [31:0] n32;
		logic [31:0] r32;
		n32       = 32'(arm_limit);
		r32       = 32'(in_data.random_arm);
		explore   = (epsilon_q != '0) && ({2'b00, in_data.random_draw} <= epsilon_q);
		rand_pick = (r32 < n32) ? 4'(r32) : 4'(n32 - 32'd1);
	end

	assign restart_now = in_xfer && (in_data.opcode == OP_RESTART);
	assign write_now   = state_q == S_WRITE;
	assign arm_ok      = 32'(in_data.arm) < 32'(ARMS);

	// scan token enters the first cell on a greedy select
	always_comb begin
		tok[0].valid = in_xfer && (in_data.opcode == OP_SELECT) && !explore;
		tok[0].empty = 1'b1;
		tok[0].value = EST_MIN;
		tok_idx[0]   = '0;
	end

	// arm cells
	for (genvar g = 0; g < ARMS; g++) begin : g_cell
		egas_cell #(
			.ARMS     (ARMS),
			.CELL_IDX (g)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.arm_limit   (arm_limit),
			.ctl         (ctl[g]),
			.tok_in      (tok[g]),
			.tok_idx_in  (tok_idx[g]),
			.tok_out     (tok[g+1]),
			.tok_idx_out (tok_idx[g+1]),
			.count       (cnt_arr[g]),
			.est         (est_arr[g])
		);
	end

	// cell loads: restart hits every cell, a reward write hits one
	always_comb begin
		for (int i = 0; i < ARMS; i++) begin
			ctl[i].load  = restart_now || (write_now && (upd_arm_q == IDX_W'(i)));
			ctl[i].count = restart_now ? '0 : new_cnt_q;
			ctl[i].est   = restart_now ? {init_value_q, 8'h00} : est_new;
		end
	end

	// fetch: saturating count and reward minus estimate
	assign fetch_cnt     = cnt_arr[upd_arm_q];
	assign fetch_est     = est_arr[upd_arm_q];
	assign fetch_cnt_inc = (fetch_cnt == CNT_MAX) ? fetch_cnt : fetch_cnt + 1'b1;
	assign fetch_diff    = $signed({reward_q[15], reward_q, 8'h00})
	                     - $signed({fetch_est[EST_W-1], fetch_est});

	// divider works on magnitudes, sign restored at write
	assign diff_mag = diff_q[DIVD_W-1] ? DIVD_W'(-diff_q) : DIVD_W'(diff_q);

	egas_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_PREP),
		.dividend (diff_mag),
		.divisor  (new_cnt_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// new estimate, truncated toward zero, saturated to the estimate range
	always_comb begin
		step_signed = diff_q[DIVD_W-1] ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		est_sum     = $signed({{2{est_old_q[EST_W-1]}}, est_old_q}) + step_signed;
		if (est_sum > $signed({{2{1'b0}}, EST_MAX})) begin
			est_new = EST_MAX;
		end else if (est_sum < $signed({{2{1'b1}}, EST_MIN})) begin
			est_new = EST_MIN;
		end else begin
			est_new = EST_W'(est_sum);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q     <= '0;
			init_value_q  <= '0;
			arms_in_use_q <= 5'd10;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_EPSILON: begin
					epsilon_q <= cfg_data[17:0];
				end
				REG_INIT_VALUE: begin
					init_value_q <= cfg_data[15:0];
				end
				REG_ARMS_IN_USE: begin
					arms_in_use_q <= cfg_data[4:0];
				end
				default: begin
				end
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result enters when the register is empty or draining
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						case (in_data.opcode)
							OP_SELECT: begin
								state_q <= explore ? S_EMIT : S_SCAN;
							end
							OP_UPDATE: begin
								state_q <= arm_ok ? S_FETCH : S_IDLE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (tok[ARMS].valid) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_FETCH: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_xfer) begin
			res_q.chosen_arm <= rand_pick;
			res_q.explored   <= 1'b1;
			upd_arm_q        <= IDX_W'(in_data.arm);
			reward_q         <= in_data.reward;
		end
		if (state_q == S_SCAN && tok[ARMS].valid) begin
			res_q.chosen_arm <= 4'(tok_idx[ARMS]);
			res_q.explored   <= 1'b0;
		end
		if (state_q == S_EMIT && out_free) begin
			out_q <= res_q;
		end
		if (state_q == S_FETCH) begin
			new_cnt_q <= fetch_cnt_inc;
			est_old_q <= fetch_est;
			diff_q    <= fetch_diff;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: test/arm_choice_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_choice_checker: predicts and checks the arm choices of the selector
// keeps its own copy of the registers, pull counts and running means, and
// compares every result transfer with the oldest predicted choice
// ----------------------------------------------------------------------------
module arm_choice_checker #(
	parameter int ARMS = egas_pkg::ARMS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  egas_pkg::in_item_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  egas_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [egas_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [egas_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              awaiting,
	output int                              explore_count
);
	import egas_pkg::*;

	logic [CFG_DATA_W-1:0]   epsilon_q;
	logic signed [15:0]      init_q;
	logic [4:0]              arms_q;
	logic [CNT_W-1:0]        pulls [ARMS];
	logic signed [EST_W-1:0] means [ARMS];
	out_item_t               pending_choices [$];
	out_item_t               want;
	int                      errs;
	int                      explores;

	function automatic out_item_t pick_arm(in_item_t it);
		int        lim;
		int        best;
		out_item_t c;
		lim = (arms_q < 1) ? 1 : ((arms_q > ARMS) ? ARMS : int'(arms_q));
		if (epsilon_q != '0 && it.random_draw <= epsilon_q) begin
			c.chosen_arm = (int'(it.random_arm) < lim) ? it.random_arm : 4'(lim - 1);
			c.explored   = 1'b1;
		end else begin
			best = 0;
			for (int i = 1; i < lim; i++)
				if (means[i] > means[best])
					best = i;
			c.chosen_arm = 4'(best);
			c.explored   = 1'b0;
		end
		return c;
	endfunction

	// running mean step, quotient truncated toward zero
	task automatic fold_reward(input logic [3:0] idx, input logic signed [15:0] rwd);
		int diff;
		int step;
		int sum;
		if (int'(idx) >= ARMS)
			return;
		if (pulls[idx] != CNT_MAX)
			pulls[idx] = pulls[idx] + 1'b1;
		diff = int'(rwd) * 256 - int'(means[idx]);
		step = diff / int'(pulls[idx]);
		sum  = int'(means[idx]) + step;
		if (sum > int'(EST_MAX))
			sum = int'(EST_MAX);
		if (sum < int'(EST_MIN))
			sum = int'(EST_MIN);
		means[idx] = EST_W'(sum);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q = '0;
			init_q    = '0;
			arms_q    = 5'd10;
			for (int i = 0; i < ARMS; i++) begin
				pulls[i] = '0;
				means[i] = '0;
			end
			pending_choices.delete();
			errs     = 0;
			explores = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_choices.size() == 0) begin
					errs++;
					$display("%0t: unexpected result: expected none, got arm %0d explored %0b",
						$time, out_data.chosen_arm, out_data.explored);
				end else begin
					want = pending_choices.pop_front();
					if (want.explored)
						explores++;
					if (out_data.chosen_arm !== want.chosen_arm) begin
						errs++;
						$display("%0t: chosen_arm mismatch: expected %0d, got %0d",
							$time, want.chosen_arm, out_data.chosen_arm);
					end
					if (out_data.explored !== want.explored) begin
						errs++;
						$display("%0t: explored mismatch: expected %0b, got %0b",
							$time, want.explored, out_data.explored);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_EPSILON:     epsilon_q = cfg_data;
					REG_INIT_VALUE:  init_q = cfg_data[15:0];
					REG_ARMS_IN_USE: arms_q = cfg_data[4:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				case (in_data.opcode)
					OP_SELECT: pending_choices = {pending_choices, pick_arm(in_data)};
					OP_UPDATE: fold_reward(in_data.arm, in_data.reward);
					OP_RESTART: begin
						for (int i = 0; i < ARMS; i++) begin
							pulls[i] = '0;
							means[i] = EST_W'(int'(init_q) * 256);
						end
					end
					default: ;
				endcase
			end
		end
		mismatches    <= errs;
		awaiting      <= pending_choices.size();
		explore_count <= explores;
	end

endmodule

FILE: test/epsilon_greedy_arm_selector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epsilon_greedy_arm_selector_tb: stimulus and verdict for the arm selector
// a short directed run over the register and field extremes, then random
// rounds of selects, reward updates and restarts under several settings,
// with random idle cycles on the input side and back-pressure on the output
// ----------------------------------------------------------------------------
module epsilon_greedy_arm_selector_tb;
	import egas_pkg::*;

	localparam int ROUNDS       = 6;
	localparam int ROUND_ITEMS  = 215;
	// covers the longest update with no result plus a greedy scan
	localparam int DRAIN_CYCLES = 64;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// calm turns off idling on both sides for a whole round
	logic                  calm;
	logic [CFG_DATA_W-1:0] eps_now;
	int                    fails;
	int                    awaiting;
	int                    explored;
	int                    n_select;
	int                    n_update;
	int                    n_restart;
	int                    n_noop;
	int                    n_settings;

	epsilon_greedy_arm_selector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	arm_choice_checker u_choice_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (fails),
		.awaiting      (awaiting),
		.explore_count (explored)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side back-pressure, out_stall drawn high with a chance of about 27 in 100
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 27);
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	function automatic in_item_t item_of(opcode_t op, int draw, int rarm, int uarm, int rwd);
		in_item_t it;
		it.opcode      = op;
		it.random_draw = 16'(draw);
		it.random_arm  = 4'(rarm);
		it.arm         = 4'(uarm);
		it.reward      = 16'(rwd);
		return it;
	endfunction

	// random item: mostly selects and updates, some restarts and no-ops
	function automatic in_item_t random_item();
		in_item_t it;
		int       roll;
		int       d;
		it.random_draw = 16'($urandom);
		it.random_arm  = 4'($urandom);
		it.arm         = 4'($urandom);
		it.reward      = 16'($urandom);
		roll = $urandom_range(99);
		if (roll < 42)
			it.opcode = OP_SELECT;
		else if (roll < 88)
			it.opcode = OP_UPDATE;
		else if (roll < 93)
			it.opcode = OP_RESTART;
		else
			it.opcode = OP_NONE;
		// draws right around epsilon hit the explore threshold on both sides
		if ($urandom_range(99) < 30) begin
			d = int'(eps_now) + int'($urandom_range(2)) - 1;
			if (d < 0)
				d = 0;
			if (d > 65535)
				d = 65535;
			it.random_draw = 16'(d);
		end
		// a small set of rewards gives equal estimates, so ties in the argmax
		if ($urandom_range(99) < 40) begin
			case ($urandom_range(4))
				0:       it.reward = -16'sd32768;
				1:       it.reward = 16'sd32767;
				2:       it.reward = 16'sd0;
				3:       it.reward = 16'sd256;
				default: it.reward = -16'sd256;
			endcase
		end
		return it;
	endfunction

	// one input transfer, with an optional idle gap in front
	task automatic send(input in_item_t it);
		if (!calm && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
		case (it.opcode)
			OP_SELECT:  n_select++;
			OP_UPDATE:  n_update++;
			OP_RESTART: n_restart++;
			default:    n_noop++;
		endcase
	endtask

	// hold off the sender until every predicted choice is back,
	// then let a trailing update finish
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaiting != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// unused upper data bits are filled at random
	task automatic set_regs(input logic [CFG_DATA_W-1:0] eps, input logic signed [15:0] init,
		input logic [4:0] arms);
		put_reg(REG_EPSILON, eps);
		put_reg(REG_INIT_VALUE, {2'($urandom_range(3)), init});
		put_reg(REG_ARMS_IN_USE, {13'($urandom), arms});
		cfg_valid  <= 1'b0;
		eps_now    = eps;
		n_settings++;
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_stall  = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = REG_EPSILON;
		cfg_data   = '0;
		calm       = 1'b0;
		eps_now    = '0;
		n_select   = 0;
		n_update   = 0;
		n_restart  = 0;
		n_noop     = 0;
		n_settings = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: greedy over ten arms, all estimates zero
		send(item_of(OP_SELECT, 0, 0, 0, 0));
		send(item_of(OP_UPDATE, 0, 0, 15, 32767));
		send(item_of(OP_UPDATE, 0, 0, 3, -32768));
		send(item_of(OP_UPDATE, 0, 0, 9, 32767));
		send(item_of(OP_SELECT, 16'hffff, 15, 0, 0));
		send(item_of(OP_UPDATE, 0, 0, 9, -32768));
		send(item_of(OP_UPDATE, 0, 0, 0, 0));
		send(item_of(OP_SELECT, 0, 0, 0, 0));
		send(item_of(OP_NONE, 16'hffff, 15, 15, -1));
		send(item_of(OP_RESTART, 0, 0, 0, 0));
		send(item_of(OP_SELECT, 0, 0, 0, 0));

		// epsilon of two: always explore; zero arms acts as one arm
		drain();
		set_regs(18'd131072, -16'sd32768, 5'd0);
		send(item_of(OP_SELECT, 16'hffff, 15, 0, 0));
		send(item_of(OP_SELECT, 0, 7, 0, 0));
		send(item_of(OP_RESTART, 0, 0, 0, 0));
		send(item_of(OP_UPDATE, 0, 0, 1, -32768));

		// all-ones epsilon, arm count beyond the array, largest initial value
		drain();
		set_regs('1, 16'sd32767, 5'd31);
		send(item_of(OP_RESTART, 0, 0, 0, 0));
		send(item_of(OP_SELECT, 16'hffff, 15, 0, 0));
		send(item_of(OP_SELECT, 0, 0, 0, 0));

		// draws on, above and below a small epsilon
		drain();
		set_regs(18'd1000, 16'sh1234, 5'd16);
		send(item_of(OP_SELECT, 1000, 3, 0, 0));
		send(item_of(OP_SELECT, 1001, 3, 0, 0));
		send(item_of(OP_SELECT, 999, 12, 0, 0));
		send(item_of(OP_UPDATE, 0, 0, 15, 32767));
		send(item_of(OP_SELECT, 1001, 0, 0, 0));

		// random rounds, each under its own register setting
		for (int r = 0; r < ROUNDS; r++) begin
			drain();
			calm <= (r == 2);
			case (r)
				0:       set_regs(18'd0, 16'($urandom), 5'd16);
				1:       set_regs(18'd6554, 16'($urandom), 5'($urandom_range(1, 16)));
				2:       set_regs(18'd32768, 16'($urandom), 5'd1);
				3:       set_regs(18'($urandom), 16'($urandom), 5'($urandom));
				4:       set_regs(18'd13107, -16'sd32768, 5'd10);
				default: set_regs(18'd0, 16'sd32767, 5'd31);
			endcase
			for (int k = 0; k < ROUND_ITEMS; k++)
				send(random_item());
		end

		drain();
		$display("covered %0d selects (%0d explored), %0d reward updates, %0d restarts, %0d no-ops",
			n_select, explored, n_update, n_restart, n_noop);
		$display("under %0d register settings, epsilon and arm count taken to both ends",
			n_settings);
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
